// File: hw/rtl/nds_pkg.sv
`timescale 1ns / 1ps
// Package for the nutrient dosing sequencer: field widths, reset values,
// phase codes, register indexes and the structs shared between modules.
// No dependencies.
package nds_pkg;

  localparam int EC_W      = 10;
  localparam int PH_W      = 11;
  localparam int TIME_W    = 18;
  localparam int ATTEMPT_W = 4;
  localparam int PHASE_W   = 4;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  localparam int MAX_ATTEMPTS_DEFAULT = 10;

  // Decision bands, in hundredths.
  localparam logic [EC_W:0]   EC_BAND = (EC_W + 1)'(15);
  localparam logic [PH_W:0]   PH_BAND = (PH_W + 1)'(20);
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Register reset values.
  localparam logic [EC_W-1:0]   TARGET_EC_RST   = EC_W'(100);
  localparam logic [PH_W-1:0]   TARGET_PH_RST   = PH_W'(580);
  localparam logic [TIME_W-1:0] DOSE_N_RST      = TIME_W'(1500);
  localparam logic [TIME_W-1:0] DOSE_P_RST      = TIME_W'(1500);
  localparam logic [TIME_W-1:0] DOSE_K_RST      = TIME_W'(1000);
  localparam logic [TIME_W-1:0] MIX_NUT_RST     = TIME_W'(2000);
  localparam logic [TIME_W-1:0] MIX_ACID_RST    = TIME_W'(3000);
  localparam logic [TIME_W-1:0] PULSE_ACID_RST  = TIME_W'(1500);

  // Register indexes on the configuration port.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_TARGET_EC   = 3'd0,
    REG_TARGET_PH   = 3'd1,
    REG_DOSE_N      = 3'd2,
    REG_DOSE_P      = 3'd3,
    REG_DOSE_K      = 3'd4,
    REG_MIX_NUT     = 3'd5,
    REG_MIX_ACID    = 3'd6,
    REG_PULSE_ACID  = 3'd7
  } reg_idx_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE      = 4'd0,
    PH_FILL      = 4'd1,
    PH_DOSE_N    = 4'd2,
    PH_MIX_N     = 4'd3,
    PH_DOSE_P    = 4'd4,
    PH_MIX_P     = 4'd5,
    PH_DOSE_K    = 4'd6,
    PH_MIX_K     = 4'd7,
    PH_DOSE_ACID = 4'd8,
    PH_MIX_ACID  = 4'd9
  } phase_t;

  typedef struct packed {
    logic              command;
    logic [EC_W-1:0]   measured_ec;
    logic [PH_W-1:0]   measured_ph;
    logic              tank_low;
  } tick_t;

  typedef struct packed {
    logic               pump_n;
    logic               pump_p;
    logic               pump_k;
    logic               pump_acid;
    logic               pump_water;
    logic [PHASE_W-1:0] phase;
    logic               lockout;
  } result_t;

  typedef struct packed {
    logic [EC_W-1:0]   target_ec;
    logic [PH_W-1:0]   target_ph;
    logic [TIME_W-1:0] dose_time_n;
    logic [TIME_W-1:0] dose_time_p;
    logic [TIME_W-1:0] dose_time_k;
    logic [TIME_W-1:0] mix_time_nutrient;
    logic [TIME_W-1:0] mix_time_acid;
    logic [TIME_W-1:0] pulse_time_acid;
  } cfg_t;

  typedef struct packed {
    phase_t               phase;
    logic [TIME_W-1:0]    elapsed_ticks;
    logic [ATTEMPT_W-1:0] attempt_count;
    logic                 lockout_flag;
  } state_t;

endpackage

// File: hw/rtl/nds_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
// Depends on nds_pkg for widths, reset values and register indexes.
module nds_cfg_regs
  import nds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_next;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;

  // Write decode: each register takes the low bits of the write data.
  always_comb begin
    cfg_next = cfg;
    if (wr_en) begin
      unique case (idx)
        REG_TARGET_EC:  cfg_next.target_ec         = pwdata[EC_W-1:0];
        REG_TARGET_PH:  cfg_next.target_ph         = pwdata[PH_W-1:0];
        REG_DOSE_N:     cfg_next.dose_time_n       = pwdata[TIME_W-1:0];
        REG_DOSE_P:     cfg_next.dose_time_p       = pwdata[TIME_W-1:0];
        REG_DOSE_K:     cfg_next.dose_time_k       = pwdata[TIME_W-1:0];
        REG_MIX_NUT:    cfg_next.mix_time_nutrient = pwdata[TIME_W-1:0];
        REG_MIX_ACID:   cfg_next.mix_time_acid     = pwdata[TIME_W-1:0];
        REG_PULSE_ACID: cfg_next.pulse_time_acid   = pwdata[TIME_W-1:0];
        default:        cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_ec         <= TARGET_EC_RST;
      cfg.target_ph         <= TARGET_PH_RST;
      cfg.dose_time_n       <= DOSE_N_RST;
      cfg.dose_time_p       <= DOSE_P_RST;
      cfg.dose_time_k       <= DOSE_K_RST;
      cfg.mix_time_nutrient <= MIX_NUT_RST;
      cfg.mix_time_acid     <= MIX_ACID_RST;
      cfg.pulse_time_acid   <= PULSE_ACID_RST;
    end else begin
      cfg <= cfg_next;
    end
  end

  // Read mux, zero extended to the bus width.
  always_comb begin
    unique case (idx)
      REG_TARGET_EC:  prdata = DATA_W'(cfg.target_ec);
      REG_TARGET_PH:  prdata = DATA_W'(cfg.target_ph);
      REG_DOSE_N:     prdata = DATA_W'(cfg.dose_time_n);
      REG_DOSE_P:     prdata = DATA_W'(cfg.dose_time_p);
      REG_DOSE_K:     prdata = DATA_W'(cfg.dose_time_k);
      REG_MIX_NUT:    prdata = DATA_W'(cfg.mix_time_nutrient);
      REG_MIX_ACID:   prdata = DATA_W'(cfg.mix_time_acid);
      REG_PULSE_ACID: prdata = DATA_W'(cfg.pulse_time_acid);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/nds_step.sv
`timescale 1ns / 1ps
// Next-state and result logic for one tick of the dosing sequencer.
// Depends on nds_pkg for the phase codes and the state, tick and result structs.
module nds_step
  import nds_pkg::*;
#(
  parameter int MAX_ATTEMPTS = MAX_ATTEMPTS_DEFAULT
) (
  input  cfg_t    cfg,
  input  state_t  state,
  input  tick_t   tick,
  output state_t  state_next,
  output result_t result
);

  localparam logic [ATTEMPT_W-1:0] ATTEMPT_LIMIT = ATTEMPT_W'(MAX_ATTEMPTS);

  logic [TIME_W-1:0] elapsed_inc;
  logic [TIME_W-1:0] limit;
  logic              timer_done;
  logic              ec_low;
  logic              ph_high;
  logic              abort_now;
  logic              at_limit;
  logic              lock_cur;
  logic [ATTEMPT_W-1:0] att_cur;
  logic              pn, pp, pk, pa, pw;

  // Saturating tick count and the time limit of the current phase.
  assign elapsed_inc = (state.elapsed_ticks == TIME_MAX) ? state.elapsed_ticks
                                                          : state.elapsed_ticks + 1'b1;
  always_comb begin
    case (state.phase)
      PH_DOSE_N:    limit = cfg.dose_time_n;
      PH_DOSE_P:    limit = cfg.dose_time_p;
      PH_DOSE_K:    limit = cfg.dose_time_k;
      PH_DOSE_ACID: limit = cfg.pulse_time_acid;
      PH_MIX_ACID:  limit = cfg.mix_time_acid;
      default:      limit = cfg.mix_time_nutrient;
    endcase
  end
  assign timer_done = elapsed_inc >= limit;

  // Dose requests from idle, compared one bit wider so the bands never wrap.
  assign ec_low  = ({1'b0, tick.measured_ec} + EC_BAND) < {1'b0, cfg.target_ec};
  assign ph_high = {1'b0, tick.measured_ph} > ({1'b0, cfg.target_ph} + PH_BAND);

  // A clear command acts before anything else on this tick.
  assign lock_cur = tick.command ? 1'b0 : state.lockout_flag;
  assign att_cur  = tick.command ? '0 : state.attempt_count;
  assign at_limit = att_cur >= ATTEMPT_LIMIT;

  // Abort once the target is reached during a mix or acid phase.
  always_comb begin
    abort_now = 1'b0;
    if ((state.phase == PH_MIX_N || state.phase == PH_MIX_P || state.phase == PH_MIX_K)
        && tick.measured_ec >= cfg.target_ec) begin
      abort_now = 1'b1;
    end
    if ((state.phase == PH_DOSE_ACID || state.phase == PH_MIX_ACID)
        && tick.measured_ph <= cfg.target_ph) begin
      abort_now = 1'b1;
    end
  end

  // Sequencer proper.
  always_comb begin
    state_next               = state;
    state_next.lockout_flag  = lock_cur;
    state_next.attempt_count = att_cur;
    pn = 1'b0;
    pp = 1'b0;
    pk = 1'b0;
    pa = 1'b0;
    pw = 1'b0;
    if (lock_cur) begin
      state_next.phase = PH_IDLE;
    end else if (abort_now) begin
      state_next.phase         = PH_IDLE;
      state_next.attempt_count = '0;
    end else begin
      unique case (state.phase) inside
        PH_IDLE: begin
          if (tick.tank_low) begin
            state_next.phase = PH_FILL;
          end else if (ec_low || ph_high) begin
            if (at_limit) begin
              state_next.lockout_flag = 1'b1;
            end else begin
              state_next.phase         = ec_low ? PH_DOSE_N : PH_DOSE_ACID;
              state_next.elapsed_ticks = '0;
              state_next.attempt_count = att_cur + 1'b1;
            end
          end else begin
            state_next.attempt_count = '0;
          end
        end
        PH_FILL: begin
          if (tick.tank_low) begin
            pw = 1'b1;
          end else begin
            state_next.phase = PH_IDLE;
          end
        end
        PH_DOSE_N, PH_MIX_N, PH_DOSE_P, PH_MIX_P, PH_DOSE_K, PH_MIX_K,
        PH_DOSE_ACID, PH_MIX_ACID: begin
          state_next.elapsed_ticks = elapsed_inc;
          if (timer_done) begin
            // The last mix of a chain returns to idle without clearing the count.
            case (state.phase)
              PH_DOSE_N:    state_next.phase = PH_MIX_N;
              PH_MIX_N:     state_next.phase = PH_DOSE_P;
              PH_DOSE_P:    state_next.phase = PH_MIX_P;
              PH_MIX_P:     state_next.phase = PH_DOSE_K;
              PH_DOSE_K:    state_next.phase = PH_MIX_K;
              PH_DOSE_ACID: state_next.phase = PH_MIX_ACID;
              default:      state_next.phase = PH_IDLE;
            endcase
            if (state.phase != PH_MIX_K && state.phase != PH_MIX_ACID) begin
              state_next.elapsed_ticks = '0;
            end
          end else begin
            pn = (state.phase == PH_DOSE_N);
            pp = (state.phase == PH_DOSE_P);
            pk = (state.phase == PH_DOSE_K);
            pa = (state.phase == PH_DOSE_ACID);
          end
        end
        default: begin
          state_next.phase = PH_IDLE;
        end
      endcase
    end
  end

  assign result.pump_n     = pn;
  assign result.pump_p     = pp;
  assign result.pump_k     = pk;
  assign result.pump_acid  = pa;
  assign result.pump_water = pw;
  assign result.phase      = state_next.phase;
  assign result.lockout    = state_next.lockout_flag;

endmodule

// File: hw/rtl/nutrient_dosing_sequencer.sv
`timescale 1ns / 1ps
// Top level of the nutrient dosing sequencer: input register, sequencer state,
// result register and configuration port. Depends on nds_pkg, nds_cfg_regs, nds_step.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+-----------------------------------
//   tick     | tick_valid / tick_stall    | tick_t: command, EC, pH, tank_low
//   result   | result_valid / result_stall| result_t: pumps, phase, lockout
//   config   | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// A tick is registered on transfer and processed from the input register, where
// the sequencer state and the result register update together. One tick per cycle
// is sustained unless the result side stalls, bounded by the single step stage.
// Reset is synchronous and returns the state and the register file to their
// defaults. A stall on the result side holds the result and the waiting
// tick; the input stalls only when both registers are full.
module nutrient_dosing_sequencer
  import nds_pkg::*;
#(
  parameter int MAX_ATTEMPTS = MAX_ATTEMPTS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              tick_valid,
  output logic              tick_stall,
  input  tick_t             tick,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result
);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  result_t step_result;
  tick_t   held_tick;
  logic    held_valid;
  logic    out_load_ok;
  logic    step_fire;
  logic    tick_xfer;

  nds_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nds_step #(
    .MAX_ATTEMPTS (MAX_ATTEMPTS)
  ) u_step (
    .cfg        (cfg),
    .state      (state),
    .tick       (held_tick),
    .state_next (state_next),
    .result     (step_result)
  );

  // Flow control between the input register and the result register.
  assign out_load_ok = !result_valid || !result_stall;
  assign step_fire   = held_valid && out_load_ok;
  assign tick_stall  = held_valid && !out_load_ok;
  assign tick_xfer   = tick_valid && !tick_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (tick_xfer) begin
      held_valid <= 1'b1;
    end else if (step_fire) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_xfer) begin
      held_tick <= tick;
    end
  end

  // Sequencer state advances once per processed tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= PH_IDLE;
      state.elapsed_ticks <= '0;
      state.attempt_count <= '0;
      state.lockout_flag  <= 1'b0;
    end else if (step_fire) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load_ok) begin
      result_valid <= step_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      result <= step_result;
    end
  end

  // Checks on the sequencer and the pipeline control.
  a_lockout_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.lockout |-> result.phase == PH_IDLE &&
      !(result.pump_n || result.pump_p || result.pump_k ||
        result.pump_acid || result.pump_water))
    else $error("lockout result with a pump driven or phase not idle");

  a_one_pump: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0({result.pump_n, result.pump_p, result.pump_k,
                               result.pump_acid, result.pump_water}))
    else $error("more than one pump driven at once");

  a_attempts_bound: assert property (@(posedge clk) disable iff (rst)
    state.attempt_count <= ATTEMPT_W'(MAX_ATTEMPTS))
    else $error("attempt count above its limit");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    tick_stall |-> held_valid && result_valid && result_stall)
    else $error("input stalled while the pipeline has room");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(state))
    else $error("sequencer state moved while a result was held");

endmodule
